@@ sv/nes_pkg.sv @@
// Package for the note event sequencer: sizes, op and status codes, note cell types.
package nes_pkg;

    localparam int TRACKS    = 4;
    localparam int NOTES     = 16;
    localparam int TICK_BITS = 24;

    localparam int TW  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int NW  = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam int CW  = $clog2(NOTES + 1);
    localparam int VW  = TICK_BITS - 1;
    localparam int MAX_RESULTS = TRACKS * NOTES;
    localparam int RW  = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        OP_ADD_TRACK = 3'd0,
        OP_DEL_TRACK = 3'd1,
        OP_ADD_NOTE  = 3'd2,
        OP_DEL_NOTE  = 3'd3,
        OP_STEP      = 3'd4,
        OP_RST_CUR   = 3'd5,
        OP_BAD6      = 3'd6,
        OP_BAD7      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_REJ  = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef struct packed {
        logic [VW-1:0] tick;
        logic [6:0]    pitch;
        logic [VW-1:0] dur;
        logic [6:0]    vel;
    } note_t;

    // Per-cell command issued by the controller.
    typedef enum logic [2:0] {
        CC_HOLD   = 3'd0,
        CC_INSERT = 3'd1,
        CC_REMOVE = 3'd2,
        CC_SHIFT  = 3'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t     cmd;
        logic [NW-1:0] pos;
        note_t         note;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EMIT,
        S_OUT
    } state_t;

endpackage

@@ sv/nes_cell.sv @@
// One note cell of a track: holds a note; on insert or remove it shifts with its neighbors.
module nes_cell
    import nes_pkg::*;
(
    input  logic          clk,
    input  logic [NW-1:0] idx,
    input  cell_ctl_t     ctl,
    input  note_t         from_lower,
    input  note_t         from_upper,
    output note_t         note
);

    note_t note_reg;
    note_t note_next;

    always_comb
    begin
        note_next = note_reg;
        case (ctl.cmd)
            CC_INSERT:
            begin
                if (idx == ctl.pos)
                    note_next = ctl.note;
                else if (idx > ctl.pos)
                    note_next = from_lower;
            end
            CC_REMOVE:
            begin
                if (idx >= ctl.pos)
                    note_next = from_upper;
            end
            default:
                note_next = note_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
    end

    assign note = note_reg;

endmodule

@@ sv/nes_track.sv @@
// One track's row of note cells, kept sorted by tick.
module nes_track
    import nes_pkg::*;
(
    input  logic          clk,
    input  cell_ctl_t     ctl,
    input  logic [NW-1:0] rd_idx,
    output note_t         rd_note
);

    note_t cells [NOTES];

    for (genvar k = 0; k < NOTES; k++)
    begin : g_cell
        note_t lo;
        note_t hi;
        assign lo = (k == 0) ? cells[0] : cells[(k == 0) ? 0 : k - 1];
        assign hi = (k == NOTES - 1) ? cells[k] : cells[(k == NOTES - 1) ? k : k + 1];
        nes_cell u_cell
        (
            .clk        (clk),
            .idx        (NW'(k)),
            .ctl        (ctl),
            .from_lower (lo),
            .from_upper (hi),
            .note       (cells[k])
        );
    end

    assign rd_note = cells[rd_idx];

endmodule

@@ sv/note_event_sequencer_core.sv @@
// Top level of the note event sequencer: control sequencer and track rows.
// One operation is taken at a time. Track operations end with the output
// transaction. Add note and remove note walk the track's cells one per
// cycle. A step visits used tracks in id order and walks each cursor one
// note per cycle, sending each emitted note event through the output handshake.
module note_event_sequencer_core
    import nes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], track_ident[18:3], channel[22:19], tick[46:23], pitch[53:47],
    // duration[77:54], velocity[84:78], zero fill to 88
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], out_track[17:2], out_channel[21:18], out_tick[44:22],
    // out_pitch[51:45], out_duration[74:52], out_velocity[81:75], zero fill to 88
    output logic [87:0] m_tdata,
    output logic        m_tuser,  // kind
    output logic        m_tlast   // last
);

    state_t state_reg, state_next;

    logic [TRACKS-1:0] used_reg, used_next;
    logic [15:0]       ident_reg [TRACKS];
    logic [3:0]        chan_reg  [TRACKS];
    logic [CW-1:0]     cnt_reg   [TRACKS];
    logic [NW-1:0]     cur_reg   [TRACKS];
    logic [TRACKS-1:0] cset_reg;
    logic [15:0]       next_id_reg;

    // latched operation
    op_t              op_reg;
    logic [15:0]      tid_reg;
    logic [3:0]       ch_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic [6:0]       pitch_reg;
    logic [TICK_BITS-1:0] dur_reg;
    logic [6:0]       vel_reg;

    logic [TW-1:0]    trk_reg;       // track under work
    logic [NW:0]      pos_reg;       // walk position
    logic [16:0]      prev_reg;      // last visited id in step, 17 bits wide
    logic             have_prev_reg;

    // pending output
    logic             pend_reg;      // an emitted note waits for the next to decide last
    logic [87:0]      out_data_reg;
    logic             out_kind_reg;
    logic             out_last_reg;
    logic             mval_reg;
    logic             step_done_reg;

    cell_ctl_t ctl [TRACKS];
    note_t     rd  [TRACKS];
    note_t     cur_note;

    assign cur_note = rd[trk_reg];

    for (genvar t = 0; t < TRACKS; t++)
    begin : g_trk
        nes_track u_trk
        (
            .clk     (clk),
            .ctl     (ctl[t]),
            .rd_idx  (pos_reg[NW-1:0]),
            .rd_note (rd[t])
        );
    end

    // input fields
    op_t                   in_op;
    logic signed [TICK_BITS-1:0] in_tick_s;
    logic signed [TICK_BITS-1:0] tick_s, dur_s;
    assign tick_s = tick_reg;
    assign dur_s  = dur_reg;
    assign in_op = op_t'(s_tdata[2:0]);
    assign in_tick_s = s_tdata[46:23];

    // find track by id (small, TRACKS compares)
    logic          fnd;
    logic [TW-1:0] fnd_s;
    always_comb
    begin
        fnd = 1'b0;
        fnd_s = '0;
        for (int s = TRACKS - 1; s >= 0; s--)
            if (used_reg[s] && ident_reg[s] == tid_reg)
            begin
                fnd = 1'b1;
                fnd_s = TW'(s);
            end
    end

    // lowest free slot
    logic          fre;
    logic [TW-1:0] fre_s;
    always_comb
    begin
        fre = 1'b0;
        fre_s = '0;
        for (int s = TRACKS - 1; s >= 0; s--)
            if (!used_reg[s])
            begin
                fre = 1'b1;
                fre_s = TW'(s);
            end
    end

    // next track in id order above prev
    logic          nxt;
    logic [TW-1:0] nxt_s;
    always_comb
    begin
        nxt = 1'b0;
        nxt_s = '0;
        for (int s = 0; s < TRACKS; s++)
            if (used_reg[s] && (!have_prev_reg || {1'b0, ident_reg[s]} > prev_reg) &&
                (!nxt || ident_reg[s] < ident_reg[nxt_s]))
            begin
                nxt = 1'b1;
                nxt_s = TW'(s);
            end
    end

    logic signed [TICK_BITS-1:0] cell_tick;
    assign cell_tick = {1'b0, cur_note.tick};

    logic [87:0] status_word;
    logic [1:0]  st_val;
    logic [15:0] st_trk;
    assign status_word = {70'd0, st_trk, st_val};

    logic [87:0] note_word;
    assign note_word = {6'd0, cur_note.vel, cur_note.dur, cur_note.pitch, cur_note.tick,
                        chan_reg[trk_reg], ident_reg[trk_reg], 2'd0};

    // sequential working values
    logic [TRACKS-1:0] cset_next;
    logic [NW-1:0]     cur_next [TRACKS];
    logic [CW-1:0]     cnt_next [TRACKS];
    logic [15:0]       next_id_next;
    logic [TW-1:0]     trk_next;
    logic [NW:0]       pos_next;
    logic [16:0]       prev_next;
    logic              have_prev_next;
    logic              load_out, load_kind, load_last, load_pend;
    logic [87:0]       load_data;
    logic              set_ident;
    logic              step_done_next;
    logic              flush_pend;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;
        cset_next = cset_reg;
        cur_next = cur_reg;
        cnt_next = cnt_reg;
        next_id_next = next_id_reg;
        trk_next = trk_reg;
        pos_next = pos_reg;
        prev_next = prev_reg;
        have_prev_next = have_prev_reg;
        load_out = 1'b0;
        load_kind = 1'b0;
        load_last = 1'b0;
        load_pend = pend_reg;
        load_data = status_word;
        st_val = ST_DONE;
        st_trk = '0;
        set_ident = 1'b0;
        step_done_next = step_done_reg;
        flush_pend = 1'b0;
        for (int t = 0; t < TRACKS; t++)
        begin
            ctl[t].cmd = CC_HOLD;
            ctl[t].pos = pos_reg[NW-1:0];
            ctl[t].note = '{tick: tick_reg[VW-1:0], pitch: pitch_reg,
                            dur: dur_reg[VW-1:0], vel: vel_reg};
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                    pos_next = '0;
                    have_prev_next = 1'b0;
                    step_done_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_ADD_TRACK:
                    begin
                        load_out = 1'b1;
                        if (next_id_reg == 16'd0 || !fre)
                            st_val = ST_FULL;
                        else
                        begin
                            set_ident = 1'b1;
                            used_next[fre_s] = 1'b1;
                            cnt_next[fre_s] = '0;
                            cset_next[fre_s] = 1'b0;
                            cur_next[fre_s] = '0;
                            next_id_next = next_id_reg + 16'd1;
                            st_trk = next_id_reg;
                        end
                        load_data = status_word;
                        state_next = S_OUT;
                    end
                    OP_DEL_TRACK:
                    begin
                        load_out = 1'b1;
                        if (!fnd)
                            st_val = ST_REJ;
                        else
                        begin
                            used_next[fnd_s] = 1'b0;
                            cnt_next[fnd_s] = '0;
                            cset_next[fnd_s] = 1'b0;
                        end
                        load_data = status_word;
                        state_next = S_OUT;
                    end
                    OP_ADD_NOTE, OP_DEL_NOTE:
                    begin
                        trk_next = fnd_s;
                        if (!fnd || (op_reg == OP_ADD_NOTE && (tick_s < 0 || dur_s <= 0)))
                        begin
                            st_val = ST_REJ;
                            load_out = 1'b1;
                            load_data = status_word;
                            state_next = S_OUT;
                        end
                        else if (op_reg == OP_ADD_NOTE && cnt_reg[fnd_s] >= CW'(NOTES))
                        begin
                            st_val = ST_FULL;
                            load_out = 1'b1;
                            load_data = status_word;
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_SCAN;
                    end
                    OP_STEP:
                    begin
                        // pick next track in id order
                        if (!nxt)
                        begin
                            flush_pend = 1'b1;
                            step_done_next = 1'b1;
                            state_next = pend_reg ? S_OUT : S_IDLE;
                        end
                        else
                        begin
                            trk_next = nxt_s;
                            prev_next = {1'b0, ident_reg[nxt_s]};
                            have_prev_next = 1'b1;
                            if (cset_reg[nxt_s])
                                pos_next = {1'b0, cur_reg[nxt_s]};
                            else
                                pos_next = '0;
                            if (!cset_reg[nxt_s] && cnt_reg[nxt_s] == '0)
                                state_next = S_EXEC;
                            else
                            begin
                                cset_next[nxt_s] = 1'b1;
                                cur_next[nxt_s] = cset_reg[nxt_s] ? cur_reg[nxt_s] : '0;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    OP_RST_CUR:
                    begin
                        for (int t = 0; t < TRACKS; t++)
                        begin
                            cset_next[t] = 1'b0;
                            cur_next[t] = '0;
                        end
                        load_out = 1'b1;
                        load_data = status_word;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        st_val = ST_REJ;
                        load_out = 1'b1;
                        load_data = status_word;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SCAN:
            begin
                case (op_reg)
                    OP_ADD_NOTE:
                    begin
                        // advance while note tick <= new tick
                        if (pos_reg < (NW+1)'(cnt_reg[trk_reg]) && cell_tick <= tick_s)
                            pos_next = pos_reg + 1'b1;
                        else
                        begin
                            ctl[trk_reg].cmd = CC_INSERT;
                            cnt_next[trk_reg] = cnt_reg[trk_reg] + 1'b1;
                            if (cset_reg[trk_reg] && pos_reg <= {1'b0, cur_reg[trk_reg]})
                                cur_next[trk_reg] = cur_reg[trk_reg] + 1'b1;
                            load_out = 1'b1;
                            load_data = status_word;
                            state_next = S_OUT;
                        end
                    end
                    OP_DEL_NOTE:
                    begin
                        if (pos_reg >= (NW+1)'(cnt_reg[trk_reg]))
                        begin
                            st_val = ST_REJ;
                            load_out = 1'b1;
                            load_data = status_word;
                            state_next = S_OUT;
                        end
                        else if (cell_tick == tick_s && cur_note.pitch == pitch_reg)
                        begin
                            ctl[trk_reg].cmd = CC_REMOVE;
                            cnt_next[trk_reg] = cnt_reg[trk_reg] - 1'b1;
                            if (cset_reg[trk_reg])
                            begin
                                if (pos_reg < {1'b0, cur_reg[trk_reg]})
                                    cur_next[trk_reg] = cur_reg[trk_reg] - 1'b1;
                                else if (pos_reg == {1'b0, cur_reg[trk_reg]} &&
                                         {1'b0, cur_reg[trk_reg]} >=
                                         CW'(cnt_reg[trk_reg] - 1'b1))
                                begin
                                    cset_next[trk_reg] = 1'b0;
                                    cur_next[trk_reg] = '0;
                                end
                            end
                            load_out = 1'b1;
                            load_data = status_word;
                            state_next = S_OUT;
                        end
                        else
                            pos_next = pos_reg + 1'b1;
                    end
                    default:
                    begin
                        // step: move cursor past notes below tick
                        if (cell_tick < tick_s)
                        begin
                            if ({1'b0, pos_reg} + 1'b1 >= {1'b0, cnt_reg[trk_reg]})
                            begin
                                cset_next[trk_reg] = 1'b0;
                                cur_next[trk_reg] = '0;
                                state_next = S_EXEC;
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                                cur_next[trk_reg] = NW'(pos_reg + 1'b1);
                            end
                        end
                        else
                            state_next = S_EMIT;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (pos_reg < (NW+1)'(cnt_reg[trk_reg]) && cell_tick == tick_s)
                begin
                    // hold the previous note until we know if another follows
                    if (pend_reg)
                        state_next = S_OUT;
                    else
                    begin
                        load_out = 1'b1;
                        load_kind = 1'b1;
                        load_data = note_word;
                        load_pend = 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else
                    state_next = S_EXEC;
            end
            S_OUT:
            begin
                if (m_tvalid && m_tready)
                begin
                    load_pend = 1'b0;
                    if (op_reg != OP_STEP)
                        state_next = S_IDLE;
                    else if (step_done_reg)
                        state_next = S_IDLE;
                    else
                        state_next = S_EMIT;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (flush_pend)
            load_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            cset_reg <= '0;
            next_id_reg <= 16'd1;
            pend_reg <= 1'b0;
            mval_reg <= 1'b0;
            step_done_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            for (int t = 0; t < TRACKS; t++)
            begin
                cnt_reg[t] <= '0;
                cur_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            cset_reg <= cset_next;
            cur_reg <= cur_next;
            cnt_reg <= cnt_next;
            next_id_reg <= next_id_next;
            pend_reg <= load_pend;
            step_done_reg <= step_done_next;
            have_prev_reg <= have_prev_next;
            if (state_reg == S_OUT && m_tready)
                mval_reg <= 1'b0;
            if (state_next == S_OUT && state_reg != S_OUT)
                mval_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            op_reg <= in_op;
            tid_reg <= s_tdata[18:3];
            ch_reg <= s_tdata[22:19];
            tick_reg <= in_tick_s;
            pitch_reg <= s_tdata[53:47];
            dur_reg <= s_tdata[77:54];
            vel_reg <= s_tdata[84:78];
        end
        if (set_ident)
        begin
            ident_reg[fre_s] <= next_id_reg;
            chan_reg[fre_s] <= ch_reg;
        end
        trk_reg <= trk_next;
        pos_reg <= pos_next;
        prev_reg <= prev_next;
        if (load_out)
        begin
            out_data_reg <= load_data;
            out_kind_reg <= load_kind;
            out_last_reg <= 1'b0;
        end
        if (load_last)
            out_last_reg <= 1'b1;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
